// File: design/bots_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bulk-only transport host sequencer package
// Shared types and protocol constants for the sequencer, its result queue
// and the top level.
// ----------------------------------------------------------------------------
package bots_pkg;

  localparam logic [31:0] CBW_SIGNATURE = 32'h5553_4243;
  localparam logic [31:0] CSW_SIGNATURE = 32'h5553_4253;
  localparam logic [31:0] CBW_LENGTH    = 32'd31;
  localparam logic [31:0] CSW_LENGTH    = 32'd13;
  localparam logic [7:0]  FLAG_DATA_IN  = 8'h80;
  localparam logic [4:0]  CB_LENGTH_MAX = 5'd16;
  localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd3;

  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_WRAP_SENT = 3'd1;
  localparam logic [2:0] OP_DATA_DONE = 3'd2;
  localparam logic [2:0] OP_STATUS    = 3'd3;
  localparam logic [2:0] OP_RECO_DONE = 3'd4;

  localparam logic [2:0] ACT_SEND_WRAPPER = 3'd0;
  localparam logic [2:0] ACT_READ_DATA    = 3'd1;
  localparam logic [2:0] ACT_WRITE_DATA   = 3'd2;
  localparam logic [2:0] ACT_READ_STATUS  = 3'd3;
  localparam logic [2:0] ACT_CLEAR_IN     = 3'd4;
  localparam logic [2:0] ACT_CLEAR_OUT    = 3'd5;
  localparam logic [2:0] ACT_RECOVERY     = 3'd6;
  localparam logic [2:0] ACT_FINISHED     = 3'd7;

  localparam logic [1:0] DIR_NO_DATA = 2'd0;
  localparam logic [1:0] DIR_IN      = 2'd1;
  localparam logic [1:0] DIR_OUT     = 2'd2;

  localparam logic [1:0] FIN_PASSED  = 2'd0;
  localparam logic [1:0] FIN_CHECK   = 2'd1;
  localparam logic [1:0] FIN_REMOVED = 2'd2;

  localparam logic [7:0] CODE_PASSED = 8'd0;
  localparam logic [7:0] CODE_FAILED = 8'd1;

  localparam int unsigned RES_FIFO_AW    = 2;
  localparam int unsigned RES_FIFO_DEPTH = 1 << RES_FIFO_AW;

  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  command_length;
    logic [1:0]  direction;
    logic [2:0]  command_lun;
    logic [31:0] buffer_length;
    logic [31:0] bytes_moved;
    logic [31:0] status_signature;
    logic [31:0] status_tag;
    logic [31:0] status_residue;
    logic [7:0]  status_code;
    logic        recovery_removed;
  } bots_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] wrapper_tag;
    logic [31:0] transfer_length;
    logic [7:0]  flag_byte;
    logic [2:0]  wrapper_lun;
    logic [4:0]  wrapper_cb_length;
    logic [1:0]  final_status;
    logic        last;
  } bots_res_t;

endpackage

// File: design/bulk_only_transport_host_sequencer_unit.sv
`timescale 1ns / 1ps
// Each event word is registered, then its result words are offered from the queue.
// Throughput: one event word per cycle; an event that causes two result words
// takes the output channel one word at a time, and the input stalls while the
// four-entry result queue has fewer than two free entries.
// Reset: the phase returns to idle, the tag counter and retry budget return to zero,
// the result queue empties and the retry limit register returns to three.
// ----------------------------------------------------------------------------
// Bulk-only transport host sequencer
// Input register, sequencer core (combinational next-state logic) and result queue for the
// host side of the mass-storage bulk-only protocol.
// ----------------------------------------------------------------------------
module bulk_only_transport_host_sequencer_unit
  import bots_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [4:0]  command_length_i,
  input  logic [1:0]  direction_i,
  input  logic [2:0]  command_lun_i,
  input  logic [31:0] buffer_length_i,
  input  logic [31:0] bytes_moved_i,
  input  logic [31:0] status_signature_i,
  input  logic [31:0] status_tag_i,
  input  logic [31:0] status_residue_i,
  input  logic [7:0]  status_code_i,
  input  logic        recovery_removed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [31:0] wrapper_tag_o,
  output logic [31:0] transfer_length_o,
  output logic [7:0]  flag_byte_o,
  output logic [2:0]  wrapper_lun_o,
  output logic [4:0]  wrapper_cb_length_o,
  output logic [1:0]  final_status_o,
  output logic        last_o
);

  bots_item_t item_q;
  logic       in_valid_q;
  logic       room2;
  logic       fire;
  logic [1:0] res_cnt;
  bots_res_t  res0, res1, out_word;

  assign fire       = in_valid_q && room2;
  assign in_stall_o = in_valid_q && !room2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.operation        <= operation_i;
      item_q.command_length   <= command_length_i;
      item_q.direction        <= direction_i;
      item_q.command_lun      <= command_lun_i;
      item_q.buffer_length    <= buffer_length_i;
      item_q.bytes_moved      <= bytes_moved_i;
      item_q.status_signature <= status_signature_i;
      item_q.status_tag       <= status_tag_i;
      item_q.status_residue   <= status_residue_i;
      item_q.status_code      <= status_code_i;
      item_q.recovery_removed <= recovery_removed_i;
    end
  end

  bots_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item_q),
    .res_cnt_o   (res_cnt),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  bots_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word)
  );

  assign action_o            = out_word.action;
  assign wrapper_tag_o       = out_word.wrapper_tag;
  assign transfer_length_o   = out_word.transfer_length;
  assign flag_byte_o         = out_word.flag_byte;
  assign wrapper_lun_o       = out_word.wrapper_lun;
  assign wrapper_cb_length_o = out_word.wrapper_cb_length;
  assign final_status_o      = out_word.final_status;
  assign last_o              = out_word.last;

endmodule

// File: design/bots_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bulk-only transport sequencer core
// Holds the command state and, for each registered event word, computes the
// next state and up to two result words combinationally.
// ----------------------------------------------------------------------------
module bots_seq
  import bots_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       fire_i,
  input  bots_item_t item_i,
  output logic [1:0] res_cnt_o,
  output bots_res_t  res0_o,
  output bots_res_t  res1_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_WRAP = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_STAT = 3'd3;
  localparam logic [2:0] PH_RECO = 3'd4;

  logic [7:0]  retry_limit_q;
  logic [2:0]  phase_q, phase_d;
  logic [31:0] tag_q, tag_d;
  logic [7:0]  retries_q, retries_d;
  logic        first_q, first_d;
  logic [31:0] rem_q, rem_d;
  logic [1:0]  dir_q, dir_d;
  logic [2:0]  lun_q, lun_d;
  logic [4:0]  cbl_q, cbl_d;
  logic        rad_q, rad_d;

  logic [2:0]  act0, act1;
  logic [1:0]  fin0;

  function automatic bots_res_t build(input logic [2:0] act, input logic [1:0] fin,
                                      input logic lst, input logic [31:0] tag,
                                      input logic [31:0] rem, input logic [1:0] dir,
                                      input logic [2:0] lun, input logic [4:0] cbl);
    bots_res_t r;
    r.action      = act;
    r.wrapper_tag = tag;
    if (act == ACT_SEND_WRAPPER || act == ACT_READ_DATA || act == ACT_WRITE_DATA) begin
      r.transfer_length = rem;
    end else if (act == ACT_READ_STATUS) begin
      r.transfer_length = CSW_LENGTH;
    end else begin
      r.transfer_length = '0;
    end
    r.flag_byte         = (act == ACT_SEND_WRAPPER && dir == DIR_IN) ? FLAG_DATA_IN : 8'd0;
    r.wrapper_lun       = (act == ACT_SEND_WRAPPER) ? lun : 3'd0;
    r.wrapper_cb_length = (act == ACT_SEND_WRAPPER) ? cbl : 5'd0;
    r.final_status      = (act == ACT_FINISHED) ? fin : FIN_PASSED;
    r.last              = lst;
    return r;
  endfunction

  always_comb begin
    phase_d   = phase_q;
    tag_d     = tag_q;
    retries_d = retries_q;
    first_d   = first_q;
    rem_d     = rem_q;
    dir_d     = dir_q;
    lun_d     = lun_q;
    cbl_d     = cbl_q;
    rad_d     = rad_q;
    res_cnt_o = 2'd0;
    act0      = ACT_FINISHED;
    act1      = ACT_READ_STATUS;
    fin0      = FIN_PASSED;
    case (item_i.operation)
      OP_START: begin
        tag_d     = tag_q + 32'd1;
        retries_d = retry_limit_q;
        first_d   = 1'b1;
        rad_d     = 1'b0;
        rem_d     = item_i.buffer_length;
        dir_d     = item_i.direction;
        lun_d     = item_i.command_lun;
        cbl_d     = (item_i.command_length > CB_LENGTH_MAX) ? CB_LENGTH_MAX
                                                            : item_i.command_length;
        phase_d   = PH_WRAP;
        act0      = ACT_SEND_WRAPPER;
        res_cnt_o = 2'd1;
      end
      OP_WRAP_SENT: begin
        if (phase_q == PH_WRAP) begin
          res_cnt_o = 2'd1;
          if (item_i.bytes_moved != CBW_LENGTH) begin
            if (retries_q <= 8'd1) begin
              retries_d = '0;
              phase_d   = PH_IDLE;
              act0      = ACT_FINISHED;
              fin0      = FIN_REMOVED;
            end else begin
              retries_d = retries_q - 8'd1;
              rad_d     = 1'b1;
              phase_d   = PH_RECO;
              act0      = ACT_RECOVERY;
            end
          end else if (rem_q != '0 && (dir_q == DIR_IN || dir_q == DIR_OUT)) begin
            phase_d = PH_DATA;
            act0    = (dir_q == DIR_IN) ? ACT_READ_DATA : ACT_WRITE_DATA;
          end else begin
            phase_d = PH_STAT;
            act0    = ACT_READ_STATUS;
          end
        end
      end
      OP_DATA_DONE: begin
        if (phase_q == PH_DATA) begin
          phase_d = PH_STAT;
          if (item_i.bytes_moved != rem_q) begin
            res_cnt_o = 2'd2;
            act0      = (dir_q == DIR_IN) ? ACT_CLEAR_IN : ACT_CLEAR_OUT;
          end else begin
            res_cnt_o = 2'd1;
            act0      = ACT_READ_STATUS;
          end
        end
      end
      OP_STATUS: begin
        if (phase_q == PH_STAT) begin
          res_cnt_o = 2'd1;
          if (item_i.bytes_moved != CSW_LENGTH) begin
            if (first_q) begin
              first_d   = 1'b0;
              res_cnt_o = 2'd2;
              act0      = ACT_CLEAR_IN;
            end else begin
              rad_d   = 1'b0;
              phase_d = PH_RECO;
              act0    = ACT_RECOVERY;
            end
          end else if (item_i.status_signature != CSW_SIGNATURE || item_i.status_tag != tag_q
                       || item_i.status_code > CODE_FAILED
                       || item_i.status_residue > rem_q) begin
            rad_d   = 1'b0;
            phase_d = PH_RECO;
            act0    = ACT_RECOVERY;
          end else if (item_i.status_code == CODE_PASSED && item_i.status_residue != '0) begin
            rem_d   = rem_q - item_i.status_residue;
            phase_d = PH_WRAP;
            act0    = ACT_SEND_WRAPPER;
          end else begin
            phase_d = PH_IDLE;
            act0    = ACT_FINISHED;
            fin0    = (item_i.status_code == CODE_FAILED) ? FIN_CHECK : FIN_PASSED;
          end
        end
      end
      OP_RECO_DONE: begin
        if (phase_q == PH_RECO) begin
          res_cnt_o = 2'd1;
          if (item_i.recovery_removed) begin
            phase_d = PH_IDLE;
            act0    = ACT_FINISHED;
            fin0    = FIN_REMOVED;
          end else if (!rad_q && retries_q <= 8'd1) begin
            retries_d = '0;
            phase_d   = PH_IDLE;
            act0      = ACT_FINISHED;
            fin0      = FIN_REMOVED;
          end else begin
            if (!rad_q) begin
              retries_d = retries_q - 8'd1;
            end
            phase_d = PH_WRAP;
            act0    = ACT_SEND_WRAPPER;
          end
        end
      end
      default: begin
        res_cnt_o = 2'd0;
      end
    endcase
    if (!fire_i) begin
      res_cnt_o = 2'd0;
    end
    res0_o = build(act0, fin0, res_cnt_o != 2'd2, tag_d, rem_d, dir_d, lun_d, cbl_d);
    res1_o = build(act1, FIN_PASSED, 1'b1, tag_d, rem_d, dir_d, lun_d, cbl_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RETRY_LIMIT_RESET;
      phase_q       <= PH_IDLE;
      tag_q         <= '0;
      retries_q     <= '0;
      first_q       <= 1'b1;
      rem_q         <= '0;
      dir_q         <= '0;
      lun_q         <= '0;
      cbl_q         <= '0;
      rad_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        retry_limit_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        phase_q   <= phase_d;
        tag_q     <= tag_d;
        retries_q <= retries_d;
        first_q   <= first_d;
        rem_q     <= rem_d;
        dir_q     <= dir_d;
        lun_q     <= lun_d;
        cbl_q     <= cbl_d;
        rad_q     <= rad_d;
      end
    end
  end

endmodule

// File: design/bots_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two result words per cycle and hands out one
// word per cycle on the output channel while the output is not stalled.
// ----------------------------------------------------------------------------
module bots_fifo
  import bots_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  bots_res_t  push0_i,
  input  bots_res_t  push1_i,
  output logic       room2_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output bots_res_t  out_word_o
);

  localparam logic [RES_FIFO_AW:0] DEPTH = (RES_FIFO_AW + 1)'(RES_FIFO_DEPTH);

  bots_res_t              mem_q [RES_FIFO_DEPTH];
  logic [RES_FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_FIFO_AW:0]   count_q;
  logic                   pop;
  logic [RES_FIFO_AW-1:0] wr_ptr_p1;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = count_q != '0;
  assign out_word_o  = mem_q[rd_ptr_q];
  assign room2_o     = count_q <= DEPTH - (RES_FIFO_AW + 1)'(2);
  assign wr_ptr_p1   = wr_ptr_q + RES_FIFO_AW'(1);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_p1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RES_FIFO_AW'(push_cnt_i);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + RES_FIFO_AW'(1);
      end
      count_q <= count_q + (RES_FIFO_AW + 1)'(push_cnt_i) - (RES_FIFO_AW + 1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH) else $error("result queue count exceeds depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> room2_o) else $error("result pushed without room");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_cnt_i == 2'd0) |=> count_q == $past(count_q) - (RES_FIFO_AW + 1)'(1))
    else $error("result queue count did not drop on pop");
`endif

endmodule
